[hdl/cbor_pkg.sv]
// ----------------------------------------------------------------------------
// cbor_pkg
// shared types and codes for the cbor item head decoder
// ----------------------------------------------------------------------------
package cbor_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ARG     = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RK_UINT = 2'd0,
        RK_LEN  = 2'd1,
        RK_BYTE = 2'd2,
        RK_ERR  = 2'd3
    } kind_t;

    // command codes sampled on an initial byte
    localparam logic [1:0] CMD_UINT  = 2'd0;
    localparam logic [1:0] CMD_BYTES = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;
    localparam logic [1:0] CMD_BAD   = 2'd3;

    // major types
    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_BYTES = 3'd2;
    localparam logic [2:0] MT_TEXT  = 3'd3;

    // additional info thresholds
    localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
    localparam logic [4:0] AI_FOUR_BYTE = 5'd26;
    localparam logic [4:0] AI_RESERVED  = 5'd28;

    typedef struct packed {
        logic [7:0]  stream_byte;
        logic [1:0]  command;
        logic [16:0] length_limit;
    } in_beat_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [63:0] value;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  read_kind;
        logic [3:0]  arg_bytes_left;
        logic [63:0] accumulator;
        logic [15:0] payload_left;
        logic [16:0] held_limit;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_IDLE,
        read_kind:      2'd0,
        arg_bytes_left: 4'd0,
        accumulator:    64'd0,
        payload_left:   16'd0,
        held_limit:     17'd0
    };

endpackage

[hdl/cbor_step.sv]
// ----------------------------------------------------------------------------
// cbor_step
// next state and result for one stream byte
// ----------------------------------------------------------------------------
module cbor_step (
    input  cbor_pkg::state_t   state,
    input  cbor_pkg::in_beat_t beat,
    output cbor_pkg::state_t   state_next,
    output logic               res_valid,
    output cbor_pkg::out_beat_t res
);

    logic [2:0]  major;
    logic [4:0]  info;
    logic [2:0]  want;
    logic        idle_err;
    logic        idle_imm;
    logic [63:0] acc_shift;
    logic [3:0]  left_dec;
    logic        arg_done;
    logic [15:0] pl_dec;
    logic        pl_done;
    logic [63:0] fin_arg;
    logic [1:0]  fin_kind;
    logic [16:0] fin_limit;
    logic        fin_fail;
    logic        fin_zero;

    assign major = beat.stream_byte[7:5];
    assign info  = beat.stream_byte[4:0];

    always_comb
    begin
        unique case (beat.command)
            cbor_pkg::CMD_UINT:  want = cbor_pkg::MT_UINT;
            cbor_pkg::CMD_BYTES: want = cbor_pkg::MT_BYTES;
            default:             want = cbor_pkg::MT_TEXT;
        endcase
    end

    assign idle_err = (beat.command == cbor_pkg::CMD_BAD) || (major != want)
                   || (info >= cbor_pkg::AI_RESERVED)
                   || ((beat.command != cbor_pkg::CMD_UINT)
                       && (info >= cbor_pkg::AI_FOUR_BYTE));
    assign idle_imm = info < cbor_pkg::AI_ONE_BYTE;

    assign acc_shift = {state.accumulator[55:0], beat.stream_byte};
    assign left_dec  = (state.arg_bytes_left != 4'd0) ? state.arg_bytes_left - 4'd1 : 4'd0;
    assign arg_done  = left_dec == 4'd0;
    assign pl_dec    = (state.payload_left != 16'd0) ? state.payload_left - 16'd1 : 16'd0;
    assign pl_done   = pl_dec == 16'd0;

    // argument completion, either after the last argument byte or immediate
    assign fin_arg   = (state.phase == cbor_pkg::PH_ARG) ? acc_shift : {59'd0, info};
    assign fin_kind  = (state.phase == cbor_pkg::PH_ARG) ? state.read_kind : beat.command;
    assign fin_limit = (state.phase == cbor_pkg::PH_ARG) ? state.held_limit
                                                         : beat.length_limit;
    assign fin_zero  = fin_arg == 64'd0;

    always_comb
    begin
        case (fin_kind)
            cbor_pkg::CMD_BYTES: fin_fail = fin_arg != {47'd0, fin_limit};
            cbor_pkg::CMD_TEXT:  fin_fail = fin_arg >= {47'd0, fin_limit};
            default:             fin_fail = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state;
        unique case (state.phase)
            cbor_pkg::PH_ARG:
            begin
                state_next.accumulator    = acc_shift;
                state_next.arg_bytes_left = left_dec;
            end
            cbor_pkg::PH_PAYLOAD:
            begin
                state_next.payload_left = pl_dec;
                if (pl_done)
                begin
                    state_next.phase = cbor_pkg::PH_IDLE;
                end
            end
            default:
            begin
                state_next.phase = cbor_pkg::PH_IDLE;
                if (beat.command != cbor_pkg::CMD_BAD)
                begin
                    state_next.read_kind  = beat.command;
                    state_next.held_limit = beat.length_limit;
                end
                if (!idle_err && !idle_imm)
                begin
                    state_next.arg_bytes_left = 4'b0001 << info[1:0];
                    state_next.accumulator    = 64'd0;
                    state_next.phase          = cbor_pkg::PH_ARG;
                end
            end
        endcase

        if ((state.phase != cbor_pkg::PH_PAYLOAD) && (state.phase != cbor_pkg::PH_ARG)
            && idle_err)
        begin
            state_next.arg_bytes_left = 4'd0;
            state_next.payload_left   = 16'd0;
        end
        else if (((state.phase == cbor_pkg::PH_ARG) && arg_done)
              || ((state.phase != cbor_pkg::PH_ARG) && (state.phase != cbor_pkg::PH_PAYLOAD)
                  && idle_imm))
        begin
            state_next.phase = cbor_pkg::PH_IDLE;
            if ((fin_kind != cbor_pkg::CMD_UINT) && fin_fail)
            begin
                state_next.arg_bytes_left = 4'd0;
                state_next.payload_left   = 16'd0;
            end
            else if ((fin_kind != cbor_pkg::CMD_UINT) && !fin_zero)
            begin
                state_next.payload_left = fin_arg[15:0];
                state_next.phase        = cbor_pkg::PH_PAYLOAD;
            end
        end
    end

    // result
    always_comb
    begin
        res_valid       = 1'b0;
        res.result_kind = cbor_pkg::RK_ERR;
        res.value       = 64'd0;
        res.last        = 1'b1;
        unique case (state.phase)
            cbor_pkg::PH_PAYLOAD:
            begin
                res_valid       = 1'b1;
                res.result_kind = cbor_pkg::RK_BYTE;
                res.value       = {56'd0, beat.stream_byte};
                res.last        = pl_done;
            end
            default:
            begin
                if ((state.phase != cbor_pkg::PH_ARG) && idle_err)
                begin
                    res_valid = 1'b1;
                end
                else if ((state.phase == cbor_pkg::PH_ARG) ? arg_done : idle_imm)
                begin
                    res_valid = 1'b1;
                    if (fin_kind == cbor_pkg::CMD_UINT)
                    begin
                        res.result_kind = cbor_pkg::RK_UINT;
                        res.value       = fin_arg;
                    end
                    else if (!fin_fail)
                    begin
                        res.result_kind = cbor_pkg::RK_LEN;
                        res.value       = fin_arg;
                        res.last        = fin_zero;
                    end
                end
            end
        endcase
    end

endmodule

[hdl/cbor_result_fifo.sv]
// ----------------------------------------------------------------------------
// cbor_result_fifo
// two-entry result buffer between the decoder and the result channel
// ----------------------------------------------------------------------------
module cbor_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cbor_pkg::out_beat_t push_data,
    output logic                full,
    output logic                result_valid,
    input  logic                result_stall,
    output cbor_pkg::out_beat_t result
);

    cbor_pkg::out_beat_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full         = count_reg == 2'd2;
    assign result_valid = count_reg != 2'd0;
    assign result       = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/cbor_head_decoder.sv]
// ----------------------------------------------------------------------------
// cbor_head_decoder
// cbor item head decoder for unsigned integers, byte strings and text strings
// ----------------------------------------------------------------------------
//
//  channel   valid         stall         payload   beat
//  --------  ------------  ------------  --------  ---------------------------
//  item      item_valid    item_stall    item      stream byte, command, length limit
//  result    result_valid  result_stall  result    kind, value, last
//
//  one stream byte per cycle while item_stall is low; each beat is decoded in the cycle it is taken
//  and its result, if any, lands in the result buffer at that same edge
//  the rate is set by the single state register loop (phase, counters, acc)
//  reset clears the parser state to idle and empties the result buffer
//  item_stall rises only when both result buffer entries hold a beat
// ----------------------------------------------------------------------------
module cbor_head_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  cbor_pkg::in_beat_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output cbor_pkg::out_beat_t result
);

    cbor_pkg::state_t    state_reg, state_next;
    cbor_pkg::out_beat_t step_res;
    logic                step_valid;
    logic                accept;
    logic                fifo_full;

    // a beat is taken whenever the result buffer has a free entry
    assign item_stall = fifo_full;
    assign accept     = item_valid && !item_stall;

    // combinational decode of one byte against the current parser state
    cbor_step u_step (
        .state      (state_reg),
        .beat       (item),
        .state_next (state_next),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    // parser state only moves on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbor_pkg::STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result buffer decouples the two sides
    cbor_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && step_valid),
        .push_data    (step_res),
        .full         (fifo_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
